FILE: sv/bmm_pkg.sv
`default_nettype none

package bmm_pkg;

  localparam int unsigned MAX_DIM_DEFAULT = 64;

  localparam int unsigned SIZE_W  = 7;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned PIXEL_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Request types
  localparam logic [1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B     = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [INDEX_W-1:0] row_index;
    logic [INDEX_W-1:0] col_index;
    logic [PIXEL_W-1:0] pixel_value;
  } bmm_req_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] product_pixel;
    logic [INDEX_W-1:0] out_row;
    logic [INDEX_W-1:0] out_col;
    logic               out_of_range;
  } bmm_res_t;

endpackage

`default_nettype wire

FILE: sv/byte_matrix_multiply_unit.sv
`default_nettype none

// Byte matrix multiply unit. Matrix A (rows_a x inner_size) and matrix B
// (inner_size x cols_b) live in two single-port-read synchronous memories of
// MAX_DIM*MAX_DIM bytes each, addressed row*MAX_DIM+col. A load request writes
// one element; loads outside the configured sizes are dropped. A compute
// request returns one element of A*B, summed modulo 256. It reads one A/B
// pair per cycle from the two memories and accumulates it; the request goes
// through the RUN, LAST and HOLD states before the result reaches the output
// register, and the next request is taken once it is there. A request outside
// the result size, or any compute request while inner_size is zero, goes
// through the HOLD state alone into the output register, with zero and, when
// outside, out_of_range set. Sizes
// larger than MAX_DIM act as MAX_DIM. A finished result sits in an output
// register, so the next request is taken while it waits; a further result
// stalls the input for as long as the one before it is not taken.
// Elements must be loaded before they are used: the memories have no reset.
module byte_matrix_multiply_unit #(
  parameter int unsigned MAX_DIM = bmm_pkg::MAX_DIM_DEFAULT
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  bmm_pkg::bmm_req_t                  in_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output bmm_pkg::bmm_res_t                  out_data,
  input  wire                                cfg_wr_en,
  input  wire [bmm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [bmm_pkg::SIZE_W-1:0]          cfg_wr_data
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_DIM);
  localparam logic [8:0]    MAX_W      = 9'(MAX_DIM);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [bmm_pkg::SIZE_W-1:0] rows_a_r, inner_size_r, cols_b_r;
  logic [8:0] m_eff, n_eff, p_eff;

  logic [1:0] state_r, state_nxt;
  logic [bmm_pkg::INDEX_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [bmm_pkg::SIZE_W-1:0]  k_r, k_nxt, n_r, n_nxt;
  logic [bmm_pkg::PIXEL_W-1:0] acc_r, acc_nxt;
  logic oor_r, oor_nxt;
  logic rd_vld_r;

  logic out_valid_r, out_valid_nxt;
  bmm_pkg::bmm_res_t out_data_r, out_data_nxt;

  logic [bmm_pkg::PIXEL_W-1:0] mem_a [DEPTH];
  logic [bmm_pkg::PIXEL_W-1:0] mem_b [DEPTH];
  logic [bmm_pkg::PIXEL_W-1:0] a_rd_r, b_rd_r;
  logic [AW-1:0] wr_addr, a_rd_addr, b_rd_addr;
  logic a_we, b_we, rd_en;

  logic in_xfer, row_ok_a, col_ok_a, row_ok_b, col_ok_b, res_in_range;
  logic [15:0] prod;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r     <= bmm_pkg::SIZE_W'(1);
      inner_size_r <= bmm_pkg::SIZE_W'(1);
      cols_b_r     <= bmm_pkg::SIZE_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bmm_pkg::CFG_ROWS_A:     rows_a_r     <= cfg_wr_data;
        bmm_pkg::CFG_INNER_SIZE: inner_size_r <= cfg_wr_data;
        bmm_pkg::CFG_COLS_B:     cols_b_r     <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Clamp sizes to the store dimension
  assign m_eff = ({2'b0, rows_a_r} > MAX_W)     ? MAX_W : {2'b0, rows_a_r};
  assign n_eff = ({2'b0, inner_size_r} > MAX_W) ? MAX_W : {2'b0, inner_size_r};
  assign p_eff = ({2'b0, cols_b_r} > MAX_W)     ? MAX_W : {2'b0, cols_b_r};

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  assign row_ok_a = 9'(in_data.row_index) < m_eff;
  assign col_ok_a = 9'(in_data.col_index) < n_eff;
  assign row_ok_b = 9'(in_data.row_index) < n_eff;
  assign col_ok_b = 9'(in_data.col_index) < p_eff;
  assign res_in_range = row_ok_a && col_ok_b;

  assign wr_addr = AW'(in_data.row_index) * ROW_STRIDE + AW'(in_data.col_index);
  assign a_we = in_xfer && (in_data.req_type == bmm_pkg::REQ_LOAD_A) && row_ok_a && col_ok_a;
  assign b_we = in_xfer && (in_data.req_type == bmm_pkg::REQ_LOAD_B) && row_ok_b && col_ok_b;

  assign rd_en     = (state_r == S_RUN);
  assign a_rd_addr = AW'(row_r) * ROW_STRIDE + AW'(k_r);
  assign b_rd_addr = AW'(k_r) * ROW_STRIDE + AW'(col_r);

  always_ff @(posedge clk) begin
    if (a_we) begin
      mem_a[wr_addr] <= in_data.pixel_value;
    end
    if (rd_en) begin
      a_rd_r <= mem_a[a_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      mem_b[wr_addr] <= in_data.pixel_value;
    end
    if (rd_en) begin
      b_rd_r <= mem_b[b_rd_addr];
    end
  end

  assign prod = a_rd_r * b_rd_r;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    acc_nxt       = acc_r;
    oor_nxt       = oor_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (rd_vld_r) begin
      acc_nxt = acc_r + prod[bmm_pkg::PIXEL_W-1:0];
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_data.req_type == bmm_pkg::REQ_COMPUTE)) begin
          row_nxt = in_data.row_index;
          col_nxt = in_data.col_index;
          acc_nxt = '0;
          k_nxt   = '0;
          n_nxt   = n_eff[bmm_pkg::SIZE_W-1:0];
          oor_nxt = !res_in_range;
          if (res_in_range && (n_eff != 9'd0)) begin
            state_nxt = S_RUN;
          end else begin
            state_nxt = S_HOLD;
          end
        end
      end
      S_RUN: begin
        k_nxt = k_r + bmm_pkg::SIZE_W'(1);
        if (k_nxt == n_r) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        // last pair is added on this edge
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.product_pixel = acc_r;
          out_data_nxt.out_row       = row_r;
          out_data_nxt.out_col       = col_r;
          out_data_nxt.out_of_range  = oor_r;
          state_nxt                  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    k_r        <= k_nxt;
    n_r        <= n_nxt;
    acc_r      <= acc_nxt;
    oor_r      <= oor_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: sim/tb_byte_matrix_multiply_unit.sv
`timescale 1ns / 100ps

module tb_byte_matrix_multiply_unit;

  localparam int DIM = bmm_pkg::MAX_DIM_DEFAULT;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 500;
  localparam int SETTLE_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bmm_pkg::bmm_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bmm_pkg::bmm_res_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [bmm_pkg::CFG_IDX_W-1:0] cfg_index = bmm_pkg::CFG_ROWS_A;
  logic [bmm_pkg::SIZE_W-1:0] cfg_wr_data = '0;

  byte_matrix_multiply_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stimulus side
  bmm_pkg::bmm_req_t pending_reqs[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic out_hold = 1'b0;
  event hold_kick;
  int gen_m = 1, gen_n = 1, gen_p = 1;
  bit a_loaded[DIM*DIM];
  bit b_loaded[DIM*DIM];
  int queued_live = 0;
  int size_settings = 0;

  // Predictor state
  logic [bmm_pkg::SIZE_W-1:0] mdl_rows = 7'd1, mdl_inner = 7'd1, mdl_cols = 7'd1;
  logic [bmm_pkg::PIXEL_W-1:0] mdl_a[DIM*DIM];
  logic [bmm_pkg::PIXEL_W-1:0] mdl_b[DIM*DIM];
  bmm_pkg::bmm_res_t expected_results[$];
  bmm_pkg::bmm_res_t want_res;

  int err_count = 0;
  int accepted = 0;
  int load_count = 0;
  int result_count = 0;
  int oor_count = 0;

  function automatic int clamp_size(input int v);
    return (v > DIM) ? DIM : v;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp);
    if (err_count < 40)
      $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, exp,
               result_count);
    err_count++;
  endtask

  task automatic predict_request(input bmm_pkg::bmm_req_t r);
    int m, n, p, k;
    logic [bmm_pkg::PIXEL_W-1:0] acc;
    bmm_pkg::bmm_res_t res;
    m = clamp_size(int'(mdl_rows));
    n = clamp_size(int'(mdl_inner));
    p = clamp_size(int'(mdl_cols));
    if (r.req_type == bmm_pkg::REQ_LOAD_A) begin
      load_count++;
      if (r.row_index < m && r.col_index < n)
        mdl_a[r.row_index * DIM + r.col_index] = r.pixel_value;
    end else if (r.req_type == bmm_pkg::REQ_LOAD_B) begin
      load_count++;
      if (r.row_index < n && r.col_index < p)
        mdl_b[r.row_index * DIM + r.col_index] = r.pixel_value;
    end else if (r.req_type == bmm_pkg::REQ_COMPUTE) begin
      res.out_row = r.row_index;
      res.out_col = r.col_index;
      if (r.row_index >= m || r.col_index >= p) begin
        res.product_pixel = '0;
        res.out_of_range = 1'b1;
      end else begin
        acc = '0;
        for (k = 0; k < n; k++)
          acc = acc + mdl_a[r.row_index * DIM + k] * mdl_b[k * DIM + r.col_index];
        res.product_pixel = acc;
        res.out_of_range = 1'b0;
      end
      expected_results.push_back(res);
    end
  endtask

  // Driver: present the next pending request once the previous one has transferred
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          bmm_pkg::CFG_ROWS_A:     mdl_rows = cfg_wr_data;
          bmm_pkg::CFG_INNER_SIZE: mdl_inner = cfg_wr_data;
          bmm_pkg::CFG_COLS_B:     mdl_cols = cfg_wr_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_request(in_data);
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each transfer against the oldest outstanding result
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", int'(out_data.out_row), -1);
        end else begin
          want_res = expected_results.pop_front();
          if (out_data.product_pixel !== want_res.product_pixel)
            report_mismatch("product_pixel", int'(out_data.product_pixel),
                            int'(want_res.product_pixel));
          if (out_data.out_row !== want_res.out_row)
            report_mismatch("out_row", int'(out_data.out_row), int'(want_res.out_row));
          if (out_data.out_col !== want_res.out_col)
            report_mismatch("out_col", int'(out_data.out_col), int'(want_res.out_col));
          if (out_data.out_of_range !== want_res.out_of_range)
            report_mismatch("out_of_range", int'(out_data.out_of_range),
                            int'(want_res.out_of_range));
          if (want_res.out_of_range)
            oor_count++;
        end
        result_count++;
      end
      out_ready <= !out_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering meanwhile
  initial forever begin
    @(hold_kick);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
  end

  task automatic write_size(input logic [bmm_pkg::CFG_IDX_W-1:0] idx, input int v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= v[bmm_pkg::SIZE_W-1:0];
  endtask

  task automatic set_sizes(input int m, input int n, input int p);
    write_size(bmm_pkg::CFG_ROWS_A, m);
    write_size(bmm_pkg::CFG_INNER_SIZE, n);
    write_size(bmm_pkg::CFG_COLS_B, p);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    gen_m = clamp_size(m);
    gen_n = clamp_size(n);
    gen_p = clamp_size(p);
    size_settings++;
  endtask

  task automatic queue_request(input logic [1:0] kind, input int row, input int col,
                               input int pix);
    bmm_pkg::bmm_req_t r;
    r.req_type = kind;
    r.row_index = row[bmm_pkg::INDEX_W-1:0];
    r.col_index = col[bmm_pkg::INDEX_W-1:0];
    r.pixel_value = pix[bmm_pkg::PIXEL_W-1:0];
    pending_reqs.push_back(r);
    if (kind == bmm_pkg::REQ_LOAD_A && row < gen_m && col < gen_n) begin
      a_loaded[row * DIM + col] = 1'b1;
      queued_live++;
    end else if (kind == bmm_pkg::REQ_LOAD_B && row < gen_n && col < gen_p) begin
      b_loaded[row * DIM + col] = 1'b1;
      queued_live++;
    end else if (kind == bmm_pkg::REQ_COMPUTE) begin
      queued_live++;
    end
  endtask

  // Load whatever the dot product still lacks, then ask for it
  task automatic queue_product(input int row, input int col);
    int k;
    for (k = 0; k < gen_n; k++)
      if (!a_loaded[row * DIM + k])
        queue_request(bmm_pkg::REQ_LOAD_A, row, k, $urandom_range(255));
    for (k = 0; k < gen_n; k++)
      if (!b_loaded[k * DIM + col])
        queue_request(bmm_pkg::REQ_LOAD_B, k, col, $urandom_range(255));
    queue_request(bmm_pkg::REQ_COMPUTE, row, col, $urandom_range(255));
  endtask

  task automatic run_random(input int count);
    int target, sel, row, col;
    target = queued_live + count;
    while (queued_live < target) begin
      sel = $urandom_range(99);
      row = $urandom_range(DIM - 1);
      col = $urandom_range(DIM - 1);
      if (sel < 40) begin
        queue_product($urandom_range(gen_m - 1), $urandom_range(gen_p - 1));
      end else if (sel < 70) begin
        queue_request(bmm_pkg::REQ_LOAD_A, $urandom_range(gen_m - 1),
                      $urandom_range(gen_n - 1), $urandom_range(255));
      end else if (sel < 85) begin
        queue_request(bmm_pkg::REQ_LOAD_B, $urandom_range(gen_n - 1),
                      $urandom_range(gen_p - 1), $urandom_range(255));
      end else if (sel < 93) begin
        queue_request($urandom_range(1) ? bmm_pkg::REQ_LOAD_B : bmm_pkg::REQ_LOAD_A,
                      row, col, $urandom_range(255));
      end else if (sel < 98) begin
        if (row < gen_m && col < gen_p)
          queue_product(row, col);
        else
          queue_request(bmm_pkg::REQ_COMPUTE, row, col, $urandom_range(255));
      end else begin
        queue_request(REQ_UNUSED, row, col, $urandom_range(255));
      end
    end
  endtask

  // Hold until every request has transferred and every result has come back
  task automatic wait_idle();
    int guard;
    guard = 0;
    while ((pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
           && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int mode, sub, k;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: wrapping all-ones products, dropped loads, out-of-range and unused requests
    set_sizes(3, 4, 2);
    for (k = 0; k < 4; k++)
      queue_request(bmm_pkg::REQ_LOAD_A, 2, k, 255);
    for (k = 0; k < 4; k++)
      queue_request(bmm_pkg::REQ_LOAD_B, k, 1, 255);
    queue_product(2, 1);
    queue_request(bmm_pkg::REQ_LOAD_A, 2, 0, 0);
    queue_product(2, 1);
    queue_product(0, 0);
    queue_request(bmm_pkg::REQ_COMPUTE, 3, 0, 0);
    queue_request(bmm_pkg::REQ_COMPUTE, 0, 2, 255);
    queue_request(bmm_pkg::REQ_COMPUTE, 63, 63, 0);
    queue_request(REQ_UNUSED, 63, 63, 255);
    queue_request(bmm_pkg::REQ_LOAD_A, 0, 4, 7);
    queue_request(bmm_pkg::REQ_LOAD_A, 3, 0, 7);
    queue_request(bmm_pkg::REQ_LOAD_B, 4, 0, 7);
    queue_request(bmm_pkg::REQ_LOAD_B, 0, 2, 7);
    queue_request(bmm_pkg::REQ_LOAD_A, 0, 0, 0);
    queue_product(0, 1);
    wait_idle();

    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      for (sub = 0; sub < 3; sub++) begin
        set_sizes($urandom_range(1, 10), $urandom_range(1, 10), $urandom_range(1, 10));
        if (mode == 0 && sub == 0) begin
          // sender pauses midway until everything has drained
          run_random(50);
          wait_idle();
          run_random(50);
        end else if (mode == 0 && sub == 1) begin
          -> hold_kick;
          run_random(100);
        end else begin
          run_random(100);
        end
        wait_idle();
      end
    end

    // Extremes: zero sizes, full size, sizes beyond the store
    set_sizes(0, 3, 5);
    queue_request(bmm_pkg::REQ_LOAD_A, 0, 0, 255);
    queue_request(bmm_pkg::REQ_LOAD_B, 0, 0, 255);
    queue_request(bmm_pkg::REQ_COMPUTE, 0, 0, 0);
    queue_request(bmm_pkg::REQ_COMPUTE, 0, 4, 0);
    wait_idle();
    set_sizes(2, 0, 2);
    queue_request(bmm_pkg::REQ_LOAD_A, 0, 0, 9);
    queue_product(1, 1);
    wait_idle();
    set_sizes(4, 3, 0);
    queue_request(bmm_pkg::REQ_LOAD_B, 0, 0, 9);
    queue_request(bmm_pkg::REQ_COMPUTE, 0, 0, 0);
    wait_idle();
    set_sizes(64, 64, 64);
    queue_product(63, 63);
    queue_product(0, 0);
    queue_product($urandom_range(DIM - 1), $urandom_range(DIM - 1));
    queue_request(bmm_pkg::REQ_LOAD_A, 63, 63, $urandom_range(255));
    queue_product(63, 63);
    wait_idle();
    set_sizes(127, 127, 127);
    queue_product(63, 0);
    queue_product(0, 63);
    wait_idle();
    set_sizes(65, 64, 100);
    queue_product(0, 0);
    wait_idle();
    set_sizes(1, 1, 1);
    queue_product(0, 0);
    queue_request(bmm_pkg::REQ_COMPUTE, 0, 1, 0);
    queue_request(bmm_pkg::REQ_COMPUTE, 1, 0, 0);
    wait_idle();

    if (expected_results.size() != 0)
      report_mismatch("results never returned", expected_results.size(), 0);
    $display("Run covered %0d requests (%0d loads) under %0d size settings,",
             accepted, load_count, size_settings);
    $display("with %0d results checked, %0d of them out of range.", result_count, oor_count);
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #15000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
